// File: design/kpd_pkg.sv
package kpd_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int CFG_W        = 10;
    localparam int SETTLE_W     = 8;
    localparam int RUN_W        = 8;
    localparam int KEY_W        = 4;
    localparam int VALUE_W      = 10;
    localparam int PROD_W       = 14;
    localparam int IDX_W        = 2;
    localparam int NUM_WIN      = 12;
    localparam int WIN_W        = 10;

    localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;
    localparam logic [PROD_W-1:0]  VALUE_MAX = 14'd999;

    localparam logic [KEY_W-1:0] CODE_NONE   = 4'd0;
    localparam logic [KEY_W-1:0] CODE_DIGIT9 = 4'd10;
    localparam logic [KEY_W-1:0] CODE_STAR   = 4'd11;
    localparam logic [KEY_W-1:0] CODE_HASH   = 4'd12;

    localparam logic [IDX_W-1:0] REG_STABLE_DELTA = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_LEVEL    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SETTLE_COUNT = 2'd2;

    localparam logic [CFG_W-1:0]    RST_STABLE_DELTA = 10'd6;
    localparam logic [CFG_W-1:0]    RST_MIN_LEVEL    = 10'd33;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_COUNT = 8'd3;

    // Key windows: lo inclusive, hi exclusive
    localparam logic [WIN_W-1:0] WIN_LO [NUM_WIN] = '{
        10'd34, 10'd62, 10'd100, 10'd140, 10'd175, 10'd225,
        10'd294, 10'd330, 10'd410, 10'd480, 10'd843, 10'd901
    };
    localparam logic [WIN_W-1:0] WIN_HI [NUM_WIN] = '{
        10'd60, 10'd100, 10'd135, 10'd170, 10'd220, 10'd289,
        10'd326, 10'd405, 10'd473, 10'd581, 10'd884, 10'd936
    };
    localparam logic [KEY_W-1:0] WIN_CODE [NUM_WIN] = '{
        4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd1, CODE_STAR, CODE_HASH
    };

    typedef struct packed {
        logic [CFG_W-1:0]    stable_delta;
        logic [CFG_W-1:0]    min_level;
        logic [SETTLE_W-1:0] settle_count;
    } t_cfg;

    // packed so that entry_value lands in the lowest bits
    typedef struct packed {
        logic               send_pulse;
        logic [KEY_W-1:0]   key_code;
        logic               key_event;
        logic [VALUE_W-1:0] entry_value;
    } t_result;

endpackage

// File: design/kpd_decode.sv
module kpd_decode #(
    parameter int ADC_BITS = kpd_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]      i_sample,
    output logic [kpd_pkg::KEY_W-1:0] o_key
);

    // windows are disjoint, so the hits can simply be OR-ed
    always_comb begin
        o_key = kpd_pkg::CODE_NONE;
        for (int i = 0; i < kpd_pkg::NUM_WIN; i++) begin
            if (i_sample >= ADC_BITS'(kpd_pkg::WIN_LO[i]) &&
                i_sample <  ADC_BITS'(kpd_pkg::WIN_HI[i])) begin
                o_key = o_key | kpd_pkg::WIN_CODE[i];
            end
        end
    end

endmodule

// File: design/kpd_core.sv
module kpd_core #(
    parameter int ADC_BITS = kpd_pkg::ADC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [ADC_BITS-1:0]   i_sample,
    input  kpd_pkg::t_cfg         i_cfg,
    output kpd_pkg::t_result      o_result
);

    logic [ADC_BITS-1:0]              r_prev, n_prev;
    logic [kpd_pkg::RUN_W-1:0]        r_run, n_run;
    logic [kpd_pkg::KEY_W-1:0]        r_held, n_held;
    logic [kpd_pkg::VALUE_W-1:0]      r_value, n_value;

    logic [kpd_pkg::KEY_W-1:0]        key;
    logic [ADC_BITS-1:0]              diff;
    logic                             stable;
    logic [kpd_pkg::PROD_W-1:0]       appended;

    kpd_decode #(.ADC_BITS(ADC_BITS)) u_decode (
        .i_sample (i_sample),
        .o_key    (key)
    );

    assign diff = (i_sample >= r_prev) ? (i_sample - r_prev) : (r_prev - i_sample);
    assign stable = (diff < ADC_BITS'(i_cfg.stable_delta)) &&
                    (i_sample > ADC_BITS'(i_cfg.min_level));
    // value * 10 + digit, digit = code - 1
    assign appended = kpd_pkg::PROD_W'(r_value) * kpd_pkg::PROD_W'(10)
                    + kpd_pkg::PROD_W'(key) - kpd_pkg::PROD_W'(1);

    always_comb begin
        n_prev  = i_sample;
        n_run   = r_run;
        n_held  = r_held;
        n_value = r_value;
        o_result.key_event = 1'b0;
        o_result.key_code  = kpd_pkg::CODE_NONE;
        o_result.send_pulse = 1'b0;
        if (stable) begin
            if (r_run != kpd_pkg::RUN_MAX) begin
                n_run = r_run + 1'b1;
            end
            if (n_run > i_cfg.settle_count && key != kpd_pkg::CODE_NONE && key != r_held) begin
                n_held = key;
                o_result.key_event = 1'b1;
                o_result.key_code  = key;
                if (key <= kpd_pkg::CODE_DIGIT9) begin
                    if (appended <= kpd_pkg::VALUE_MAX) begin
                        n_value = appended[kpd_pkg::VALUE_W-1:0];
                    end
                end else if (key == kpd_pkg::CODE_STAR) begin
                    n_value = '0;
                end else begin
                    o_result.send_pulse = 1'b1;
                end
            end
        end else begin
            n_run  = '0;
            n_held = kpd_pkg::CODE_NONE;
        end
        o_result.entry_value = n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_run   <= '0;
            r_held  <= kpd_pkg::CODE_NONE;
            r_value <= '0;
        end else if (i_fire) begin
            r_prev  <= n_prev;
            r_run   <= n_run;
            r_held  <= n_held;
            r_value <= n_value;
        end
    end

endmodule

// File: design/analog_keypad_number_entry.sv
// Resistor-ladder keypad decoder with debounce and 3-digit number entry. Each ADC
// sample request on the slave stream yields exactly one result request on the master
// stream: the entry value after that sample, a key event flag, the key code (digit+1,
// 11 star, 12 hash) and a send pulse for hash. Throughput is one sample per clock when
// the master stream does not stall; a sample is held in the input register, is processed
// against the debounce state in a single pass and appears from the result register.
// Configuration writes are always accepted
// (o_cfg_ready is tied high); index 0 stable_delta, 1 min_level, 2 settle_count,
// index 3 is ignored. Write them only while no samples are in flight.
module analog_keypad_number_entry #(
    parameter int ADC_BITS = kpd_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [ADC_BITS-1:0] adc_sample, rest zero
    input  logic [((ADC_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [9:0] entry_value, [10] key_event, [14:11] key_code, [15] send_pulse
    output logic [15:0]                       o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kpd_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [kpd_pkg::CFG_W-1:0]         i_cfg_data
);

    kpd_pkg::t_cfg      r_cfg;
    kpd_pkg::t_result   result;
    kpd_pkg::t_result   r_out;
    logic               r_in_valid;
    logic [ADC_BITS-1:0] r_in_sample;
    logic               r_out_valid;
    logic               s_fire;
    logic               advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_delta <= kpd_pkg::RST_STABLE_DELTA;
            r_cfg.min_level    <= kpd_pkg::RST_MIN_LEVEL;
            r_cfg.settle_count <= kpd_pkg::RST_SETTLE_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kpd_pkg::REG_STABLE_DELTA: r_cfg.stable_delta <= i_cfg_data;
                kpd_pkg::REG_MIN_LEVEL:    r_cfg.min_level    <= i_cfg_data;
                kpd_pkg::REG_SETTLE_COUNT:
                    r_cfg.settle_count <= i_cfg_data[kpd_pkg::SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage moves on when the result slot is free or being drained
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= s_fire || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && !i_m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_sample <= i_s_axis_tdata[ADC_BITS-1:0];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    kpd_core #(.ADC_BITS(ADC_BITS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_sample (r_in_sample),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule
